>>> hw/rtl/itoar_pkg.sv
package itoar_pkg;

    localparam int DIV_BITS    = 32;
    localparam int DIV10_SHIFT = 35;
    localparam logic [DIV_BITS-1:0] DIV10_MAGIC = 32'hCCCC_CCCD;

    localparam int STORE_DEPTH = 16;
    localparam int IDX_BITS    = 4;
    localparam int POS_BITS    = 6;
    localparam int TOTAL_BITS  = 7;
    localparam int SHAMT_BITS  = 7;
    localparam int DIGIT_BITS  = 4;
    localparam int CHAR_BITS   = 7;

    localparam logic [3:0] SIZE_BYTE  = 4'd1;
    localparam logic [3:0] SIZE_HALF  = 4'd2;
    localparam logic [3:0] SIZE_WORD  = 4'd4;
    localparam logic [3:0] SIZE_DWORD = 4'd8;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_UPPER_N = 7'h4E;
    localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 7'h61;

    typedef enum logic [1:0] {
        RADIX_BIN = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_DEC = 2'd2,
        RADIX_HEX = 2'd3
    } radix_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUB,
        ST_EMIT
    } state_t;

    typedef struct packed {
        radix_t radix;
        logic   nan;
    } emit_ctrl_t;

endpackage

>>> hw/rtl/itoar_div10.sv
module itoar_div10 (
    input  logic                          aclk,
    input  logic                          load,
    input  logic [itoar_pkg::DIV_BITS-1:0]   dividend,
    output logic [itoar_pkg::DIV_BITS-1:0]   quotient,
    output logic [itoar_pkg::DIGIT_BITS-1:0] remainder
);

    logic [2*itoar_pkg::DIV_BITS-1:0] prod_reg;
    logic [itoar_pkg::DIV_BITS-1:0]   dividend_reg;
    logic [3:0]                       q_lo;
    logic [3:0]                       q10_lo;

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg     <= dividend * itoar_pkg::DIV10_MAGIC;
            dividend_reg <= dividend;
        end
    end

    // The remainder is below ten, so the low four bits of the subtraction suffice.
    always_comb begin
        quotient  = itoar_pkg::DIV_BITS'(prod_reg[2*itoar_pkg::DIV_BITS-1:itoar_pkg::DIV10_SHIFT]);
        q_lo      = quotient[3:0];
        q10_lo    = 4'({q_lo[0], 3'b000} + {q_lo[2:0], 1'b0});
        remainder = dividend_reg[3:0] - q10_lo;
    end

endmodule

>>> hw/rtl/itoar_char_gen.sv
module itoar_char_gen #(
    parameter int WORK_BITS = 32
) (
    input  itoar_pkg::emit_ctrl_t             ctrl,
    input  logic [WORK_BITS-1:0]              work,
    input  logic [itoar_pkg::DIGIT_BITS-1:0]  dec_digit,
    input  logic [itoar_pkg::POS_BITS-1:0]    pos,
    output logic [itoar_pkg::CHAR_BITS-1:0]   ascii_char
);

    logic [itoar_pkg::SHAMT_BITS-1:0] shamt;
    logic [WORK_BITS-1:0]             shifted;
    logic [itoar_pkg::DIGIT_BITS-1:0] digit_mask;
    logic [itoar_pkg::DIGIT_BITS-1:0] digit;

    always_comb begin
        unique case (ctrl.radix)
            itoar_pkg::RADIX_BIN: begin
                shamt      = itoar_pkg::SHAMT_BITS'(pos);
                digit_mask = 4'h1;
            end
            itoar_pkg::RADIX_OCT: begin
                shamt      = itoar_pkg::SHAMT_BITS'(pos) + itoar_pkg::SHAMT_BITS'({pos, 1'b0});
                digit_mask = 4'h7;
            end
            itoar_pkg::RADIX_HEX: begin
                shamt      = itoar_pkg::SHAMT_BITS'({pos, 1'b0, 1'b0});
                digit_mask = 4'hF;
            end
            default: begin
                shamt      = '0;
                digit_mask = 4'hF;
            end
        endcase

        shifted = work >> shamt;
        if (ctrl.radix == itoar_pkg::RADIX_DEC) begin
            digit = dec_digit;
        end else begin
            digit = shifted[3:0] & digit_mask;
        end

        if (ctrl.nan) begin
            ascii_char = (pos == itoar_pkg::POS_BITS'(1)) ? itoar_pkg::CHAR_LOWER_A
                                                          : itoar_pkg::CHAR_UPPER_N;
        end else if (digit <= 4'd9) begin
            ascii_char = itoar_pkg::CHAR_ZERO + itoar_pkg::CHAR_BITS'(digit);
        end else begin
            ascii_char = itoar_pkg::CHAR_UPPER_A + itoar_pkg::CHAR_BITS'(digit - 4'd10);
        end
    end

endmodule

>>> hw/rtl/integer_to_ascii_radix.sv
// Formats one integer per input item as a run of ASCII characters, most significant
// first, one character per output item, with tlast on the final one and the sign flag
// in tuser. After the item is taken, binary, octal and hexadecimal runs produce one
// character per cycle straight from a shifter while the output is not stalled, up
// to 64 characters for an 8-byte operand in binary. Decimal runs through a single
// divide-by-ten unit, a registered 32 x 32 reciprocal multiply then a remainder step,
// reused for each digit in turn (at most ten digits). An invalid size yields the three
// characters NaN. The next item is accepted as soon as the last character has entered
// the output register.
module integer_to_ascii_radix #(
    parameter int VALUE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [31:0] value
    input  logic [6:0]  s_tuser,  // [3:0] size_bytes, [5:4] radix_sel, [6] is_signed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // [6:0] ascii_char, [7] zero
    output logic [0:0]  m_tuser,  // [0] negative
    output logic        m_tlast
);

    localparam int WORK_BITS = (VALUE_BITS < 16) ? 16 : VALUE_BITS;

    itoar_pkg::state_t     state_reg, state_next;
    itoar_pkg::emit_ctrl_t ctrl_reg, ctrl_next;
    logic [WORK_BITS-1:0]  work_reg, work_next;
    logic                  neg_reg, neg_next;
    logic [itoar_pkg::IDX_BITS-1:0] nd_reg, nd_next;
    logic [itoar_pkg::POS_BITS-1:0] pos_reg, pos_next;
    logic [itoar_pkg::DIGIT_BITS-1:0] store_reg [itoar_pkg::STORE_DEPTH];

    logic                  out_valid_reg, out_valid_next;
    logic [itoar_pkg::CHAR_BITS-1:0] out_char_reg, out_char_next;
    logic                  out_neg_reg, out_neg_next;
    logic                  out_last_reg, out_last_next;

    logic [31:0]           in_value;
    logic [3:0]            in_size;
    itoar_pkg::radix_t     in_radix;
    logic                  in_signed;
    logic [WORK_BITS-1:0]  in_mask;
    logic [WORK_BITS-1:0]  in_signbit;
    logic [WORK_BITS-1:0]  in_masked;
    logic                  in_neg;
    logic [WORK_BITS-1:0]  in_mag;
    logic                  in_valid_size;
    logic [1:0]            size_shift;
    logic [3:0]            per_byte;
    logic [itoar_pkg::TOTAL_BITS-1:0] total;

    logic                  accept;
    logic                  load_out;
    logic                  store_we;
    logic [itoar_pkg::DIV_BITS-1:0]   quotient;
    logic [itoar_pkg::DIGIT_BITS-1:0] remainder;
    logic [itoar_pkg::CHAR_BITS-1:0]  gen_char;

    assign in_value  = s_tdata;
    assign in_size   = s_tuser[3:0];
    assign in_radix  = itoar_pkg::radix_t'(s_tuser[5:4]);
    assign in_signed = s_tuser[6];

    always_comb begin
        in_valid_size = 1'b1;
        size_shift    = 2'd0;
        in_mask       = WORK_BITS'(8'hFF);
        in_signbit    = WORK_BITS'(8'h80);
        unique case (in_size)
            itoar_pkg::SIZE_BYTE: begin
                size_shift = 2'd0;
            end
            itoar_pkg::SIZE_HALF: begin
                size_shift = 2'd1;
                in_mask    = WORK_BITS'(16'hFFFF);
                in_signbit = WORK_BITS'(16'h8000);
            end
            itoar_pkg::SIZE_WORD, itoar_pkg::SIZE_DWORD: begin
                size_shift = (in_size == itoar_pkg::SIZE_WORD) ? 2'd2 : 2'd3;
                in_mask    = WORK_BITS'({VALUE_BITS{1'b1}});
                in_signbit = WORK_BITS'({1'b1, {(VALUE_BITS-1){1'b0}}});
            end
            default: begin
                in_valid_size = 1'b0;
            end
        endcase

        in_masked = in_value[WORK_BITS-1:0] & in_mask;
        in_neg    = in_signed && ((in_masked & in_signbit) != '0);
        in_mag    = in_neg ? ((WORK_BITS'(0) - in_masked) & in_mask) : in_masked;

        unique case (in_radix)
            itoar_pkg::RADIX_BIN: per_byte = 4'd8;
            itoar_pkg::RADIX_OCT: per_byte = 4'd3;
            itoar_pkg::RADIX_HEX: per_byte = 4'd2;
            default:              per_byte = 4'd0;
        endcase
        total = itoar_pkg::TOTAL_BITS'(per_byte) << size_shift;
    end

    itoar_div10 u_div10 (
        .aclk      (aclk),
        .load      (state_reg == itoar_pkg::ST_MUL),
        .dividend  (itoar_pkg::DIV_BITS'(work_reg)),
        .quotient  (quotient),
        .remainder (remainder)
    );

    itoar_char_gen #(
        .WORK_BITS (WORK_BITS)
    ) u_char_gen (
        .ctrl       (ctrl_reg),
        .work       (work_reg),
        .dec_digit  (store_reg[pos_reg[itoar_pkg::IDX_BITS-1:0]]),
        .pos        (pos_reg),
        .ascii_char (gen_char)
    );

    assign s_tready = (state_reg == itoar_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load_out = (state_reg == itoar_pkg::ST_EMIT) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next     = state_reg;
        ctrl_next      = ctrl_reg;
        work_next      = work_reg;
        neg_next       = neg_reg;
        nd_next        = nd_reg;
        pos_next       = pos_reg;
        store_we       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_neg_next   = out_neg_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            itoar_pkg::ST_IDLE: begin
                if (accept) begin
                    ctrl_next.radix = in_radix;
                    ctrl_next.nan   = !in_valid_size;
                    work_next       = in_mag;
                    nd_next         = '0;
                    if (!in_valid_size) begin
                        neg_next   = 1'b0;
                        pos_next   = itoar_pkg::POS_BITS'(2);
                        state_next = itoar_pkg::ST_EMIT;
                    end else if (in_radix == itoar_pkg::RADIX_DEC) begin
                        neg_next   = in_neg;
                        state_next = itoar_pkg::ST_MUL;
                    end else begin
                        neg_next   = in_neg;
                        pos_next   = itoar_pkg::POS_BITS'(total - itoar_pkg::TOTAL_BITS'(1));
                        state_next = itoar_pkg::ST_EMIT;
                    end
                end
            end
            itoar_pkg::ST_MUL: begin
                state_next = itoar_pkg::ST_SUB;
            end
            itoar_pkg::ST_SUB: begin
                store_we  = 1'b1;
                work_next = WORK_BITS'(quotient);
                nd_next   = nd_reg + itoar_pkg::IDX_BITS'(1);
                if (quotient == '0) begin
                    pos_next   = itoar_pkg::POS_BITS'(nd_reg);
                    state_next = itoar_pkg::ST_EMIT;
                end else begin
                    state_next = itoar_pkg::ST_MUL;
                end
            end
            itoar_pkg::ST_EMIT: begin
                if (load_out) begin
                    out_valid_next = 1'b1;
                    out_char_next  = gen_char;
                    out_neg_next   = neg_reg;
                    out_last_next  = (pos_reg == '0);
                    if (pos_reg == '0) begin
                        state_next = itoar_pkg::ST_IDLE;
                    end else begin
                        pos_next = pos_reg - itoar_pkg::POS_BITS'(1);
                    end
                end
            end
            default: begin
                state_next = itoar_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= itoar_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            nd_reg        <= '0;
            pos_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            nd_reg        <= nd_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        ctrl_reg     <= ctrl_next;
        work_reg     <= work_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        out_neg_reg  <= out_neg_next;
        out_last_reg <= out_last_next;
        if (store_we) begin
            store_reg[nd_reg] <= remainder;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tuser  = out_neg_reg;
    assign m_tlast  = out_last_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input accepted while a conversion was still running");

    a_mul_then_sub: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == itoar_pkg::ST_MUL) |=> (state_reg == itoar_pkg::ST_SUB))
        else $error("divide step did not follow the multiply step");

    a_dec_digit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == itoar_pkg::ST_SUB) |-> (nd_reg <= itoar_pkg::IDX_BITS'(9)))
        else $error("decimal conversion produced more than ten digits");

    a_nan_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == itoar_pkg::ST_EMIT && ctrl_reg.nan) |-> (pos_reg <= itoar_pkg::POS_BITS'(2)))
        else $error("invalid-size run longer than three characters");

endmodule

>>> tb/integer_to_ascii_radix_tb.sv
`timescale 1ns / 1ps

module integer_to_ascii_radix_tb;

    localparam int VALUE_BITS = 32;
    localparam int ITEMS_PER_PHASE = 99;

    typedef struct packed {
        logic [itoar_pkg::CHAR_BITS-1:0] ch;
        logic                            neg;
        logic                            last;
    } char_item_t;

    typedef struct {
        logic [31:0]       value;
        logic [3:0]        size;
        itoar_pkg::radix_t radix;
        bit                sgn;
        string             text;
        bit                neg;
    } number_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [6:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    char_item_t  expected_chars[$];
    number_row_t directed_rows[$];
    int          send_idle_pct = 17;
    int          recv_idle_pct = 73;
    int          error_count = 0;
    int          numbers_sent = 0;
    int          nan_numbers = 0;
    int          chars_checked = 0;
    int          negative_numbers = 0;

    integer_to_ascii_radix #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("integer_to_ascii_radix_tb: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void push_char(input logic [itoar_pkg::CHAR_BITS-1:0] ch, input bit neg,
                                      input bit last);
        char_item_t c;
        c.ch = ch;
        c.neg = neg;
        c.last = last;
        expected_chars.push_back(c);
    endfunction

    // Works out the characters of one number and queues them in output order.
    function automatic void format_number(input logic [31:0] raw, input logic [3:0] size,
                                          input itoar_pkg::radix_t radix, input bit sgn);
        logic [31:0]                     mask;
        logic [31:0]                     signbit;
        logic [31:0]                     mag;
        logic [31:0]                     base;
        logic [3:0]                      digits[32];
        logic [3:0]                      d;
        logic [itoar_pkg::CHAR_BITS-1:0] ch;
        int                              per_byte;
        int                              nd;
        int                              total;
        int                              pos;
        bit                              neg;
        neg = 1'b0;
        if (size == itoar_pkg::SIZE_BYTE) begin
            mask = 32'hFF;
            signbit = 32'h80;
        end else if (size == itoar_pkg::SIZE_HALF) begin
            mask = 32'hFFFF;
            signbit = 32'h8000;
        end else if (size == itoar_pkg::SIZE_WORD || size == itoar_pkg::SIZE_DWORD) begin
            mask = 32'hFFFF_FFFF >> (32 - VALUE_BITS);
            signbit = 32'h1 << (VALUE_BITS - 1);
        end else begin
            push_char(itoar_pkg::CHAR_UPPER_N, 1'b0, 1'b0);
            push_char(itoar_pkg::CHAR_LOWER_A, 1'b0, 1'b0);
            push_char(itoar_pkg::CHAR_UPPER_N, 1'b0, 1'b1);
            nan_numbers++;
            return;
        end
        mag = raw & mask;
        if (sgn && (mag & signbit) != 0) begin
            neg = 1'b1;
            mag = (32'h0 - mag) & mask;
        end
        case (radix)
            itoar_pkg::RADIX_BIN: begin
                base = 2;
                per_byte = 8;
            end
            itoar_pkg::RADIX_OCT: begin
                base = 8;
                per_byte = 3;
            end
            itoar_pkg::RADIX_DEC: begin
                base = 10;
                per_byte = 0;
            end
            default: begin
                base = 16;
                per_byte = 2;
            end
        endcase
        nd = 0;
        do begin
            digits[nd] = 4'(mag % base);
            nd++;
            mag = mag / base;
        end while (mag != 0 && nd < 32);
        total = per_byte * int'(size);
        if (total < nd)
            total = nd;
        for (int i = 0; i < total; i++) begin
            pos = total - 1 - i;
            d = (pos < nd) ? digits[pos] : 4'd0;
            ch = (d <= 4'd9) ? itoar_pkg::CHAR_ZERO + itoar_pkg::CHAR_BITS'(d)
                             : itoar_pkg::CHAR_UPPER_A + itoar_pkg::CHAR_BITS'(d - 4'd10);
            push_char(ch, neg, i + 1 == total);
        end
    endfunction

    task automatic send_number(input logic [31:0] v, input logic [3:0] size,
                               input itoar_pkg::radix_t radix, input bit sgn,
                               input string text, input bit neg);
        byte code;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        if (text.len() == 0) begin
            format_number(v, size, radix, sgn);
        end else begin
            for (int i = 0; i < text.len(); i++) begin
                code = text[i];
                push_char(code[6:0], neg, i == text.len() - 1);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        s_tuser <= {sgn, radix, size};
        do @(posedge aclk); while (!s_tready);
        numbers_sent++;
    endtask

    task automatic wait_drained();
        while (expected_chars.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [31:0] random_value();
        logic [31:0] edges[9];
        edges = '{32'h80, 32'h7F, 32'hFF, 32'h8000, 32'h7FFF, 32'hFFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 20);
            1: return edges[$urandom_range(0, 8)];
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] random_size();
        case ($urandom_range(0, 9))
            0: return 4'($urandom_range(0, 15));
            1, 2, 3: return itoar_pkg::SIZE_BYTE;
            4, 5, 6: return itoar_pkg::SIZE_HALF;
            7, 8: return itoar_pkg::SIZE_WORD;
            default: return itoar_pkg::SIZE_DWORD;
        endcase
    endfunction

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        char_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected item tdata=%h tuser=%b tlast=%b",
                                          m_tdata, m_tuser, m_tlast));
            end else begin
                want = expected_chars.pop_front();
                chars_checked++;
                if (m_tdata !== {1'b0, want.ch})
                    report_mismatch($sformatf("tdata got %h expected %h",
                                              m_tdata, {1'b0, want.ch}));
                if (m_tuser[0] !== want.neg)
                    report_mismatch($sformatf("negative got %b expected %b",
                                              m_tuser[0], want.neg));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("tlast got %b expected %b",
                                              m_tlast, want.last));
                if (want.last && want.neg)
                    negative_numbers++;
            end
        end
    end

    initial begin
        directed_rows.push_back('{32'h0000_0000, itoar_pkg::SIZE_BYTE, itoar_pkg::RADIX_HEX,
                                  1'b0, "00", 1'b0});
        directed_rows.push_back('{32'h0000_00FF, itoar_pkg::SIZE_BYTE, itoar_pkg::RADIX_HEX,
                                  1'b0, "FF", 1'b0});
        directed_rows.push_back('{32'h0000_0080, itoar_pkg::SIZE_BYTE, itoar_pkg::RADIX_BIN,
                                  1'b1, "10000000", 1'b1});
        directed_rows.push_back('{32'h0000_00FF, itoar_pkg::SIZE_BYTE, itoar_pkg::RADIX_OCT,
                                  1'b1, "001", 1'b1});
        directed_rows.push_back('{32'hABCD_EF7F, itoar_pkg::SIZE_BYTE, itoar_pkg::RADIX_DEC,
                                  1'b1, "127", 1'b0});
        directed_rows.push_back('{32'h0000_FFFF, itoar_pkg::SIZE_HALF, itoar_pkg::RADIX_OCT,
                                  1'b0, "177777", 1'b0});
        directed_rows.push_back('{32'h1234_8000, itoar_pkg::SIZE_HALF, itoar_pkg::RADIX_HEX,
                                  1'b1, "8000", 1'b1});
        directed_rows.push_back('{32'hFFFF_8000, itoar_pkg::SIZE_HALF, itoar_pkg::RADIX_DEC,
                                  1'b1, "", 1'b0});
        directed_rows.push_back('{32'h0000_5555, itoar_pkg::SIZE_HALF, itoar_pkg::RADIX_BIN,
                                  1'b0, "", 1'b0});
        directed_rows.push_back('{32'hFFFF_FFFF, itoar_pkg::SIZE_WORD, itoar_pkg::RADIX_DEC,
                                  1'b0, "4294967295", 1'b0});
        directed_rows.push_back('{32'h8000_0000, itoar_pkg::SIZE_WORD, itoar_pkg::RADIX_DEC,
                                  1'b1, "2147483648", 1'b1});
        directed_rows.push_back('{32'hFFFF_FFFF, itoar_pkg::SIZE_WORD, itoar_pkg::RADIX_DEC,
                                  1'b1, "1", 1'b1});
        directed_rows.push_back('{32'h0000_0000, itoar_pkg::SIZE_WORD, itoar_pkg::RADIX_DEC,
                                  1'b0, "0", 1'b0});
        directed_rows.push_back('{32'hA5A5_A5A5, itoar_pkg::SIZE_WORD, itoar_pkg::RADIX_HEX,
                                  1'b0, "A5A5A5A5", 1'b0});
        directed_rows.push_back('{32'h7FFF_FFFF, itoar_pkg::SIZE_WORD, itoar_pkg::RADIX_OCT,
                                  1'b1, "", 1'b0});
        directed_rows.push_back('{32'hDEAD_BEEF, itoar_pkg::SIZE_DWORD, itoar_pkg::RADIX_HEX,
                                  1'b0, "00000000DEADBEEF", 1'b0});
        directed_rows.push_back('{32'hFFFF_FFFE, itoar_pkg::SIZE_DWORD, itoar_pkg::RADIX_DEC,
                                  1'b1, "2", 1'b1});
        directed_rows.push_back('{32'h8000_0000, itoar_pkg::SIZE_DWORD, itoar_pkg::RADIX_BIN,
                                  1'b1, "", 1'b0});
        directed_rows.push_back('{32'hFFFF_FFFF, itoar_pkg::SIZE_DWORD, itoar_pkg::RADIX_OCT,
                                  1'b0, "", 1'b0});
        directed_rows.push_back('{32'hFFFF_FFFF, 4'd0, itoar_pkg::RADIX_BIN,
                                  1'b1, "NaN", 1'b0});
        directed_rows.push_back('{32'h8000_0000, 4'd3, itoar_pkg::RADIX_DEC,
                                  1'b1, "NaN", 1'b0});
        directed_rows.push_back('{32'h0000_0000, 4'd7, itoar_pkg::RADIX_OCT,
                                  1'b0, "NaN", 1'b0});
        directed_rows.push_back('{32'h1234_5678, 4'd9, itoar_pkg::RADIX_HEX,
                                  1'b0, "NaN", 1'b0});
        directed_rows.push_back('{32'hFFFF_FFFF, 4'd15, itoar_pkg::RADIX_HEX,
                                  1'b1, "NaN", 1'b0});

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_number(directed_rows[i].value, directed_rows[i].size, directed_rows[i].radix,
                        directed_rows[i].sgn, directed_rows[i].text, directed_rows[i].neg);
        s_tvalid <= 1'b0;
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 73 : 0;
            recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 17 : 0;
            repeat (ITEMS_PER_PHASE)
                send_number(random_value(), random_size(),
                            itoar_pkg::radix_t'($urandom_range(0, 3)),
                            $urandom_range(0, 1), "", 1'b0);
            s_tvalid <= 1'b0;
            wait_drained();
        end

        repeat (70) @(posedge aclk);
        $display("Formatted %0d numbers (%0d with an invalid size, %0d negative) into %0d",
                 numbers_sent, nan_numbers, negative_numbers, chars_checked);
        $display("characters across all radixes and sizes under three handshake patterns.");
        if (error_count == 0) begin
            $display("integer_to_ascii_radix_tb: done, clean");
        end else begin
            $display("integer_to_ascii_radix_tb: done, errors");
        end
        $finish;
    end

endmodule

>>> integer_to_ascii_radix.f
hw/rtl/itoar_pkg.sv
hw/rtl/itoar_div10.sv
hw/rtl/itoar_char_gen.sv
hw/rtl/integer_to_ascii_radix.sv
tb/integer_to_ascii_radix_tb.sv
